// ===== rtl/core/gcd_pkg.sv =====
// Package for the great-circle distance pipeline: fixed-point constants,
// the arctangent table and the per-stage step functions.
// Depends on nothing; used by great_circle_distance.
package gcd_pkg;

  localparam int LANES = 4;
  localparam int XY_W = 32;
  localparam int ANG_W = 35;
  localparam int VEC_W = 33;
  localparam int SQ_W = 61;
  localparam int NUM_W = 40;
  localparam int FRAC = 30;

  localparam int ROT_PER = 3;
  localparam int SQ_PER = 2;
  localparam int ROT_STEPS = 30;
  localparam int SQ_LAST = 30;

  localparam int DIFF_SHIFT = 19;
  localparam int POINT_SHIFT = 18;

  // Rounded-up reciprocal of 180 scaled by 2^48; exact for numerators below 2^40.
  localparam logic [40:0] RECIP_180 = 41'd1563749870615;
  localparam int RECIP_SH = 48;

  localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XY_W-1:0] CORDIC_K = 32'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] ROUND_Q30 = 30'd536870912;
  localparam logic [23:0] SCALE_M = 24'd12742000;
  localparam logic [24:0] DIST_MAX = 25'd20015087;
  localparam logic [24:0] OUT_MAX = 25'h1FFFFFF;

  localparam logic [29:0] ATAN_TAB [ROT_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
    30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
    30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
    30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sq_t;

  function automatic rot_t rot_chunk(input rot_t v_in, input int base);
    rot_t v;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [4:0] i;
    v = v_in;
    for (int j = 0; j < ROT_PER; j++) begin
      i = 5'(base + j);
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (!v.z[ANG_W-1]) begin
        v.x = v.x - dx;
        v.y = v.y + dy;
        v.z = v.z - $signed(ANG_W'(ATAN_TAB[i]));
      end else begin
        v.x = v.x + dx;
        v.y = v.y - dy;
        v.z = v.z + $signed(ANG_W'(ATAN_TAB[i]));
      end
    end
    return v;
  endfunction

  function automatic vec_t vec_chunk(input vec_t v_in, input int base);
    vec_t v;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic [4:0] i;
    v = v_in;
    for (int j = 0; j < ROT_PER; j++) begin
      i = 5'(base + j);
      dx = v.y >>> i;
      dy = v.x >>> i;
      if (!v.y[VEC_W-1]) begin
        v.x = v.x + dx;
        v.y = v.y - dy;
        v.z = v.z + $signed(VEC_W'(ATAN_TAB[i]));
      end else begin
        v.x = v.x - dx;
        v.y = v.y + dy;
        v.z = v.z - $signed(VEC_W'(ATAN_TAB[i]));
      end
    end
    return v;
  endfunction

  // Two steps of the digit-by-digit square root; step k tests bit 2^(60-2k).
  function automatic sq_t sq_chunk(input sq_t v_in, input int base);
    sq_t v;
    logic [SQ_W-1:0] bitv;
    int idx;
    v = v_in;
    for (int j = 0; j < SQ_PER; j++) begin
      idx = base + j;
      if (idx <= SQ_LAST) begin
        bitv = SQ_W'(1) << (2 * (SQ_LAST - idx));
        if ({1'b0, v.n} >= ({1'b0, v.r} + {1'b0, bitv})) begin
          v.n = v.n - (v.r + bitv);
          v.r = (v.r >> 1) + bitv;
        end else begin
          v.r = v.r >> 1;
        end
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/great_circle_distance.sv =====
// Great-circle distance between two points by the haversine formula.
// Top level of the pipeline; depends on gcd_pkg.
//
// The block takes one point pair per cycle while pair_ready is high and offers
// the distances in order, each after its pair has passed 54 register stages.
// The depth is set by the four 30-step CORDIC sine/cosine lanes and the
// 30-step CORDIC arctangent, three steps per stage, by the two 31-step square
// roots at two steps per stage, and by the division by 180 in the
// degree-to-radian conversion, done as a reciprocal multiplication over three
// stages. Every stage carries its own valid bit and holds only while the stage
// after it is full and stalled, so a stall at the output is absorbed by any
// empty stages before the input stops taking transactions.
module great_circle_distance (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_ready,
  input  logic signed [23:0]  lat_a,
  input  logic signed [23:0]  lat_b,
  input  logic signed [24:0]  lon_a,
  input  logic signed [24:0]  lon_b,
  output logic                dist_valid,
  input  logic                dist_ready,
  output logic [24:0]         distance_m
);

  localparam int LANES = gcd_pkg::LANES;
  localparam int DIV_ST = 3;
  localparam int ROT_ST = 10;
  localparam int SQ_ST = 16;

  localparam int ST_MAG = 0;
  localparam int ST_PROD = 1;
  localparam int ST_NUM = 2;
  localparam int ST_SIGN = ST_NUM + DIV_ST + 1;
  localparam int ST_RED = ST_SIGN + 1;
  localparam int ST_SC = ST_RED + ROT_ST + 1;
  localparam int ST_MUL1 = ST_SC + 1;
  localparam int ST_RND1 = ST_MUL1 + 1;
  localparam int ST_MUL2 = ST_RND1 + 1;
  localparam int ST_RND2 = ST_MUL2 + 1;
  localparam int ST_SUM = ST_RND2 + 1;
  localparam int ST_SQR = ST_SUM + SQ_ST + 1;
  localparam int ST_CLMP = ST_SQR + ROT_ST + 1;
  localparam int ST_DMUL = ST_CLMP + 1;
  localparam int ST_OUT = ST_DMUL + 1;
  localparam int NS = ST_OUT + 1;

  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  assign adv[NS] = dist_ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= ({vld[NS-2:0], pair_valid} & adv[NS-1:0]) | (vld & ~adv[NS-1:0]);
    end
  end

  assign pair_ready = adv[0];
  assign dist_valid = vld[ST_OUT];

  // Lanes: half latitude span, half longitude span, latitude a, latitude b.
  logic signed [26:0] span [LANES];
  assign span[0] = 27'(lat_b) - 27'(lat_a);
  assign span[1] = 27'(lon_b) - 27'(lon_a);
  assign span[2] = 27'(lat_a);
  assign span[3] = 27'(lat_b);

  logic [25:0]      mag [LANES];
  logic [LANES-1:0] sgn0;
  logic [59:0]      prod [LANES];
  logic [LANES-1:0] sgn1;

  always_ff @(posedge clk) begin
    if (adv[ST_MAG]) begin
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= span[l][26] ? 26'(-span[l]) : 26'(span[l]);
        sgn0[l] <= span[l][26];
      end
    end
    if (adv[ST_PROD]) begin
      for (int l = 0; l < LANES; l++) begin
        prod[l] <= 60'(mag[l]) * 60'(gcd_pkg::PI_Q32);
      end
      sgn1 <= sgn0;
    end
  end

  logic [gcd_pkg::NUM_W-1:0] num [LANES];
  logic [40:0]      pp_hh [LANES];
  logic [40:0]      pp_hl [LANES];
  logic [40:0]      pp_lh [LANES];
  logic [40:0]      pp_ll [LANES];
  logic [61:0]      acc_hi [LANES];
  logic [40:0]      acc_lo [LANES];
  logic [33:0]      quo [LANES];
  logic [LANES-1:0] sgnp [DIV_ST+1];

  for (genvar l = 0; l < LANES; l++) begin : g_num
    localparam int SH = (l < 2) ? gcd_pkg::DIFF_SHIFT : gcd_pkg::POINT_SHIFT;
    always_ff @(posedge clk) begin
      if (adv[ST_NUM]) begin
        num[l] <= gcd_pkg::NUM_W'((prod[l] + (60'(90) << SH)) >> SH);
        sgnp[0][l] <= sgn1[l];
      end
    end
  end

  // The division by 180 multiplies by the rounded-up reciprocal; the four
  // partial products are summed over the next two stages.
  always_ff @(posedge clk) begin
    if (adv[ST_NUM+1]) begin
      for (int l = 0; l < LANES; l++) begin
        pp_hh[l] <= 41'(num[l][39:20]) * 41'(gcd_pkg::RECIP_180[40:20]);
        pp_hl[l] <= 41'(num[l][39:20]) * 41'(gcd_pkg::RECIP_180[19:0]);
        pp_lh[l] <= 41'(num[l][19:0]) * 41'(gcd_pkg::RECIP_180[40:20]);
        pp_ll[l] <= 41'(num[l][19:0]) * 41'(gcd_pkg::RECIP_180[19:0]);
      end
      sgnp[1] <= sgnp[0];
    end
    if (adv[ST_NUM+2]) begin
      for (int l = 0; l < LANES; l++) begin
        acc_hi[l] <= (62'(pp_hh[l]) << 20) + 62'(pp_hl[l]) + 62'(pp_lh[l]);
        acc_lo[l] <= pp_ll[l];
      end
      sgnp[2] <= sgnp[1];
    end
    if (adv[ST_NUM+3]) begin
      for (int l = 0; l < LANES; l++) begin
        quo[l] <= 34'(((82'(acc_hi[l]) << 20) + 82'(acc_lo[l])) >> gcd_pkg::RECIP_SH);
      end
      sgnp[3] <= sgnp[2];
    end
  end

  logic signed [gcd_pkg::ANG_W-1:0] th [LANES];
  logic [LANES-1:0] sgn_th;
  gcd_pkg::rot_t    rt [ROT_ST+1][LANES];
  logic [LANES-1:0] ngp [ROT_ST+1];

  always_ff @(posedge clk) begin
    if (adv[ST_SIGN]) begin
      for (int l = 0; l < LANES; l++) begin
        th[l] <= gcd_pkg::ANG_W'(quo[l]);
      end
      sgn_th <= sgnp[DIV_ST];
    end
    if (adv[ST_RED]) begin
      for (int l = 0; l < LANES; l++) begin
        rt[0][l].x <= gcd_pkg::CORDIC_K;
        rt[0][l].y <= '0;
        priority if (sgn_th[l] && (th[l] > gcd_pkg::HALF_PI_Q30)) begin
          rt[0][l].z <= gcd_pkg::PI_Q30 - th[l];
          ngp[0][l] <= 1'b1;
        end else if (sgn_th[l]) begin
          rt[0][l].z <= -th[l];
          ngp[0][l] <= 1'b0;
        end else if (th[l] > gcd_pkg::HALF_PI_Q30) begin
          rt[0][l].z <= th[l] - gcd_pkg::PI_Q30;
          ngp[0][l] <= 1'b1;
        end else begin
          rt[0][l].z <= th[l];
          ngp[0][l] <= 1'b0;
        end
      end
    end
  end

  for (genvar r = 0; r < ROT_ST; r++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv[ST_RED+1+r]) begin
        for (int l = 0; l < LANES; l++) begin
          rt[r+1][l] <= gcd_pkg::rot_chunk(rt[r][l], gcd_pkg::ROT_PER * r);
        end
        ngp[r+1] <= ngp[r];
      end
    end
  end

  logic signed [gcd_pkg::XY_W-1:0] s_dlat, s_dlon, c_lat_a, c_lat_b;
  logic signed [63:0] pr_dlat, pr_dlon, pr_cos, pr_t2;
  logic signed [gcd_pkg::XY_W-1:0] t_dlat, t_dlon, cos_prod, t_dlat_d, t_dlat_e, t2;

  always_ff @(posedge clk) begin
    if (adv[ST_SC]) begin
      s_dlat  <= ngp[ROT_ST][0] ? -rt[ROT_ST][0].y : rt[ROT_ST][0].y;
      s_dlon  <= ngp[ROT_ST][1] ? -rt[ROT_ST][1].y : rt[ROT_ST][1].y;
      c_lat_a <= ngp[ROT_ST][2] ? -rt[ROT_ST][2].x : rt[ROT_ST][2].x;
      c_lat_b <= ngp[ROT_ST][3] ? -rt[ROT_ST][3].x : rt[ROT_ST][3].x;
    end
    if (adv[ST_MUL1]) begin
      pr_dlat <= 64'(s_dlat) * 64'(s_dlat);
      pr_dlon <= 64'(s_dlon) * 64'(s_dlon);
      pr_cos  <= 64'(c_lat_a) * 64'(c_lat_b);
    end
    if (adv[ST_RND1]) begin
      t_dlat   <= gcd_pkg::XY_W'((pr_dlat + $signed(64'(gcd_pkg::ROUND_Q30))) >>> gcd_pkg::FRAC);
      t_dlon   <= gcd_pkg::XY_W'((pr_dlon + $signed(64'(gcd_pkg::ROUND_Q30))) >>> gcd_pkg::FRAC);
      cos_prod <= gcd_pkg::XY_W'((pr_cos + $signed(64'(gcd_pkg::ROUND_Q30))) >>> gcd_pkg::FRAC);
    end
    if (adv[ST_MUL2]) begin
      pr_t2    <= 64'(cos_prod) * 64'(t_dlon);
      t_dlat_d <= t_dlat;
    end
    if (adv[ST_RND2]) begin
      t2       <= gcd_pkg::XY_W'((pr_t2 + $signed(64'(gcd_pkg::ROUND_Q30))) >>> gcd_pkg::FRAC);
      t_dlat_e <= t_dlat_d;
    end
  end

  logic signed [32:0] a_sum;
  logic [30:0]        a_clip;

  assign a_sum = 33'(t_dlat_e) + 33'(t2);

  always_comb begin
    priority if (a_sum[32]) begin
      a_clip = '0;
    end else if (a_sum > $signed(33'(gcd_pkg::ONE_Q30))) begin
      a_clip = gcd_pkg::ONE_Q30;
    end else begin
      a_clip = 31'(a_sum);
    end
  end

  gcd_pkg::sq_t sq [SQ_ST+1][2];

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      sq[0][0].n <= gcd_pkg::SQ_W'(a_clip) << gcd_pkg::FRAC;
      sq[0][0].r <= '0;
      sq[0][1].n <= gcd_pkg::SQ_W'(gcd_pkg::ONE_Q30 - a_clip) << gcd_pkg::FRAC;
      sq[0][1].r <= '0;
    end
  end

  for (genvar q = 0; q < SQ_ST; q++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv[ST_SUM+1+q]) begin
        for (int l = 0; l < 2; l++) begin
          sq[q+1][l] <= gcd_pkg::sq_chunk(sq[q][l], gcd_pkg::SQ_PER * q);
        end
      end
    end
  end

  gcd_pkg::vec_t vc [ROT_ST+1];

  always_ff @(posedge clk) begin
    if (adv[ST_SQR]) begin
      vc[0].y <= gcd_pkg::VEC_W'(sq[SQ_ST][0].r)
               + gcd_pkg::VEC_W'(sq[SQ_ST][0].n > sq[SQ_ST][0].r);
      vc[0].x <= gcd_pkg::VEC_W'(sq[SQ_ST][1].r)
               + gcd_pkg::VEC_W'(sq[SQ_ST][1].n > sq[SQ_ST][1].r);
      vc[0].z <= '0;
    end
  end

  for (genvar r = 0; r < ROT_ST; r++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv[ST_SQR+1+r]) begin
        vc[r+1] <= gcd_pkg::vec_chunk(vc[r], gcd_pkg::ROT_PER * r);
      end
    end
  end

  logic [30:0] z_clip;
  logic [54:0] dprod;
  logic [25:0] d_round;

  assign d_round = 26'((dprod + 55'(gcd_pkg::ROUND_Q30)) >> gcd_pkg::FRAC);

  always_ff @(posedge clk) begin
    if (adv[ST_CLMP]) begin
      priority if (vc[ROT_ST].z[gcd_pkg::VEC_W-1]) begin
        z_clip <= '0;
      end else if (vc[ROT_ST].z > gcd_pkg::HALF_PI_Q30) begin
        z_clip <= 31'(gcd_pkg::HALF_PI_Q30);
      end else begin
        z_clip <= 31'(vc[ROT_ST].z);
      end
    end
    if (adv[ST_DMUL]) begin
      dprod <= 55'(z_clip) * 55'(gcd_pkg::SCALE_M);
    end
    if (adv[ST_OUT]) begin
      distance_m <= (d_round > 26'(gcd_pkg::OUT_MAX)) ? gcd_pkg::OUT_MAX : 25'(d_round);
    end
  end

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pair_ready |-> ((&vld) && !dist_ready))
    else $error("Input stalled while the pipeline had an empty stage.");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> (distance_m <= gcd_pkg::DIST_MAX))
    else $error("Distance exceeds half the circumference.");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !dist_valid)
    else $error("Result offered directly after reset.");

endmodule

// ===== test/great_circle_distance_tb.sv =====
// Testbench for great_circle_distance: random and directed point pairs
// checked against a fixed-point haversine predictor held in a scoreboard.
// Depends on the great_circle_distance RTL and gcd_pkg only.
`timescale 1ns / 100ps

class dist_board;
  longint atan_q30[30];
  logic [24:0] pending[$];
  int errors;

  function new();
    longint sum;
    longint unsigned term;
    int e;
    errors = 0;
    atan_q30[0] = 64'd843314857;
    for (int i = 1; i < 30; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        term = (64'd1 << e) / longint'(2 * k + 1);
        sum = (k & 1) ? sum - longint'(term) : sum + longint'(term);
      end
      atan_q30[i] = longint'((longint'(sum) + 64'd2147483648) >> 32);
    end
  endfunction

  function longint to_radians(longint v, int sh);
    longint unsigned mag, d, q;
    mag = (v < 0) ? longint'(-v) : v;
    d = 64'd180 << sh;
    q = (mag * 64'h3243F6A89 + d / 2) / d;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function longint mul_q30(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function void sin_cos(longint th, output longint s, output longint c);
    bit neg;
    longint x, y, z, dx, dy;
    neg = 0;
    x = 652032874;
    y = 0;
    while (th > 64'sd1686629713) begin th = th - 64'sd3373259426; neg = !neg; end
    while (th < -64'sd1686629713) begin th = th + 64'sd3373259426; neg = !neg; end
    z = th;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_q30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_q30[i];
      end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function longint unsigned root_round(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function longint central_angle(longint yv, longint xv);
    longint x, y, z, dx, dy;
    x = xv; y = yv; z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_q30[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_q30[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd1686629713) z = 64'sd1686629713;
    return z;
  endfunction

  function void note(logic signed [23:0] la, logic signed [23:0] lb,
                     logic signed [24:0] oa, logic signed [24:0] ob);
    longint s1, c1, s2, c2, sa, ca, sb, cb, a, z;
    longint unsigned ra, rb, m;
    sin_cos(to_radians(longint'(lb) - longint'(la), 19), s1, c1);
    sin_cos(to_radians(longint'(ob) - longint'(oa), 19), s2, c2);
    sin_cos(to_radians(longint'(la), 18), sa, ca);
    sin_cos(to_radians(longint'(lb), 18), sb, cb);
    a = mul_q30(s1, s1) + mul_q30(mul_q30(ca, cb), mul_q30(s2, s2));
    if (a < 0) a = 0;
    if (a > 64'sd1073741824) a = 64'sd1073741824;
    ra = root_round(longint'(a) << 30);
    rb = root_round(longint'(64'sd1073741824 - a) << 30);
    z = central_angle(ra, rb);
    m = (longint'(z) * 64'd12742000 + 64'd536870912) >> 30;
    if (m > 64'h1FFFFFF) m = 64'h1FFFFFF;
    pending.insert(pending.size(), m[24:0]);
  endfunction

  function void check(logic [24:0] actual);
    logic [24:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected distance %0d", actual);
      return;
    end
    want = pending.pop_front();
    if (actual !== want) begin
      errors++;
      if (errors <= 10) $display("distance_m expected %0d actual %0d", want, actual);
    end
  endfunction
endclass

module great_circle_distance_tb;
  logic clk, rst;
  logic pair_valid, pair_ready, dist_valid, dist_ready;
  logic signed [23:0] lat_a, lat_b;
  logic signed [24:0] lon_a, lon_b;
  logic [24:0] distance_m;
  bit quiet;
  int hold;
  dist_board board;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;

  great_circle_distance DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("great_circle_distance_tb: errors");
    $finish;
  end

  task automatic send(int la, int lb, int oa, int ob);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pair_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pair_valid <= 1;
    lat_a <= la[23:0];
    lat_b <= lb[23:0];
    lon_a <= oa[24:0];
    lon_b <= ob[24:0];
    do @(negedge clk); while (!pair_ready);
    board.note(la[23:0], lb[23:0], oa[24:0], ob[24:0]);
    @(posedge clk);
  endtask

  task automatic send_random();
    int la, lb, oa, ob, pick;
    pick = $urandom_range(0, 9);
    la = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
    oa = $urandom_range(0, 2 * LON_MAX) - LON_MAX;
    if (pick < 5) begin
      lb = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
      ob = $urandom_range(0, 2 * LON_MAX) - LON_MAX;
    end else if (pick < 7) begin
      lb = la + $urandom_range(0, 2000) - 1000;
      ob = oa + $urandom_range(0, 2000) - 1000;
    end else if (pick < 8) begin
      lb = la;
      ob = oa;
    end else begin
      la = $urandom;
      lb = $urandom;
      oa = $urandom;
      ob = $urandom;
    end
    send(la, lb, oa, ob);
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      dist_ready <= 1;
      hold <= 0;
    end else if (hold > 0) begin
      dist_ready <= 0;
      hold <= hold - 1;
    end else if (!dist_ready) begin
      dist_ready <= 1;
    end else if ($urandom_range(0, 4) == 0) begin
      dist_ready <= 0;
      hold <= $urandom_range(0, 3);
    end else begin
      dist_ready <= 1;
    end
  end

  always @(negedge clk)
    if (!rst && dist_valid && dist_ready) board.check(distance_m);

  initial begin
    int t;
    board = new();
    quiet = 0;
    rst <= 1;
    pair_valid <= 0;
    lat_a <= 0; lat_b <= 0; lon_a <= 0; lon_b <= 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(0, 0, 0, 0);
    send(LAT_MAX, -LAT_MAX, 0, 0);
    send(LAT_MAX, LAT_MAX, LON_MAX, -LON_MAX);
    send(0, 0, LON_MAX, -LON_MAX);
    send(0, 0, 0, LON_MAX);
    send(-LAT_MAX, LAT_MAX, -LON_MAX, LON_MAX);
    send(LAT_MAX, 0, LON_MAX, 0);
    send(3000000, 3000000, 5000000, 5000000);
    send(3000000, -3000000, 100, 11796380);
    send(-8388608, 8388607, -16777216, 16777215);
    send(8388607, -8388608, 16777215, -16777216);
    send(-8388608, -8388608, -16777216, -16777216);
    send(1, 0, 0, 1);
    send(-1, 1, 1, -1);
    send(0, 0, 11796479, -11796480);
    send(2621440, -2621440, 3407872, -8388608);

    for (t = 0; t < 650; t++) send_random();
    pair_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    for (t = 0; t < 550; t++) send_random();
    quiet = 1;
    for (t = 0; t < 150; t++) send_random();
    pair_valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("great_circle_distance_tb: clean");
    else
      $display("great_circle_distance_tb: errors");
    $finish;
  end
endmodule
